[rtl/utc_pkg.sv]
// Shared types and constants for the Unix time to calendar converter.
`timescale 1ns / 1ps

package utc_pkg;

    // Reciprocal constants for exact division by multiply and shift.
    // x / 15 for x < 2**30: (x * DIV15_MUL) >> DIV15_SHIFT
    localparam logic [30:0] DIV15_MUL   = 31'd1145324613;
    localparam int          DIV15_SHIFT = 34;
    // x / 3 for x < 2**18
    localparam logic [17:0] DIV3_MUL    = 18'd174763;
    localparam int          DIV3_SHIFT  = 19;
    // x / 7305 for x < 2**26
    localparam logic [25:0] DIV7305_MUL   = 26'd37628735;
    localparam int          DIV7305_SHIFT = 38;

    // Day count at which the Gregorian skipped leap day of 2100 applies.
    localparam logic [15:0] DAY_CENT_EDGE = 16'd47541;
    // Julian day base, century correction already folded in.
    localparam logic [21:0] JD_BASE       = 22'd2442125;
    localparam logic [25:0] YR_BIAS       = 26'd2442;
    localparam logic [21:0] DAYS_PER_YEAR = 22'd365;

    // Year bases for months counted from March.
    localparam logic [12:0] YEAR_BASE_LO = 13'd6716;  // March .. December
    localparam logic [12:0] YEAR_BASE_HI = 13'd6715;  // January, February
    localparam logic [3:0]  LAST_LO_MON  = 4'd13;

    // First day (minus one) of each month in the shifted year: floor(30.601 * m).
    localparam logic [8:0] MON_START [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [15:0] day;
    } t_tod;

endpackage

[rtl/unix_time_to_calendar_top.sv]
// Top level: Unix seconds to Gregorian date and time, ten-stage pipeline.
`timescale 1ns / 1ps

// Latency: ten register stages lie between the edge that accepts start and the strobe.
// Throughput: one timestamp per cycle; busy is never raised, since every
// stage advances every cycle and results are never held off.
// Stages 1-3 each hold one reciprocal multiply, stage 4 the hour remainder;
// stages 5-10 turn the day count into year, month and day.
// Reset (synchronous, active low) clears only the valid bits; data regs float.

module unix_time_to_calendar_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_unix_seconds,
    output logic        o_strobe,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic signed [7:0] o_year_offset,
    output logic [3:0]  o_month_of_year,
    output logic [4:0]  o_day_of_month
);

    logic          w_tod_vld;
    utc_pkg::t_tod w_tod;

    // stage registers; r_sN_* is the output of stage N
    logic [5:0]    r_vld;
    utc_pkg::t_tod r_s5_tod, r_s6_tod, r_s7_tod, r_s8_tod, r_s9_tod;
    logic [21:0]   r_s5_jd, r_s6_jd, r_s7_jd;
    logic [25:0]   r_s6_x;
    logic [12:0]   r_s7_yr, r_s8_yr, r_s9_yr;
    logic [8:0]    r_s8_doy, r_s9_doy;
    logic [3:0]    r_s9_mon;

    logic [5:0]    r_o_sec;
    logic [5:0]    r_o_min;
    logic [4:0]    r_o_hour;
    logic [7:0]    r_o_year;
    logic [3:0]    r_o_mon;
    logic [4:0]    r_o_day;

    logic [21:0]   n_jd;
    logic [25:0]   n_x;
    logic [51:0]   w_yr_prod;
    logic [8:0]    n_doy;
    logic [15:1]   w_past;
    logic [3:0]    n_mon;
    logic [4:0]    n_day;
    logic [7:0]    n_year;
    logic [3:0]    n_mon_out;

    // never stalls: the pipe always advances
    assign busy = 1'b0;

    utc_tod u_tod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_secs  (i_unix_seconds),
        .o_valid (w_tod_vld),
        .o_tod   (w_tod)
    );

    // Stage 5: Julian day. Century term (4d+102032)/146097 only steps
    // once in range, at the skipped leap day of 2100.
    assign n_jd = 22'(w_tod.day) + utc_pkg::JD_BASE
                + 22'(w_tod.day >= utc_pkg::DAY_CENT_EDGE);

    // Stage 6: 20 * jd - 2442
    assign n_x = {r_s5_jd, 4'b0} + {2'b0, r_s5_jd, 2'b0} - utc_pkg::YR_BIAS;

    // Stage 7: year (March based) = x / 7305 by reciprocal multiply
    assign w_yr_prod = 52'(r_s6_x) * 52'(utc_pkg::DIV7305_MUL);

    // Stage 8: day within the March-based year, 123..488
    assign n_doy = 9'(r_s7_jd - 22'(r_s7_yr) * utc_pkg::DAYS_PER_YEAR
                 - 22'(r_s7_yr[12:2]));

    // Stage 9: month index = doy * 1000 / 30601, by threshold compares
    always_comb begin
        for (int m = 1; m < 16; m++) begin
            w_past[m] = r_s8_doy > utc_pkg::MON_START[m];
        end
    end
    assign n_mon = 4'($countones(w_past));

    // Stage 10: day of month and year / month fold-back
    assign n_day = 5'(r_s9_doy - utc_pkg::MON_START[r_s9_mon]);

    always_comb begin
        if (r_s9_mon <= utc_pkg::LAST_LO_MON) begin
            n_year    = 8'(r_s9_yr - utc_pkg::YEAR_BASE_LO);
            n_mon_out = r_s9_mon - 4'd1;
        end else begin
            // months 14 and 15 are January and February of the next year
            n_year    = 8'(r_s9_yr - utc_pkg::YEAR_BASE_HI);
            n_mon_out = r_s9_mon - utc_pkg::LAST_LO_MON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], w_tod_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_tod <= w_tod;
        r_s5_jd  <= n_jd;

        r_s6_tod <= r_s5_tod;
        r_s6_jd  <= r_s5_jd;
        r_s6_x   <= n_x;

        r_s7_tod <= r_s6_tod;
        r_s7_jd  <= r_s6_jd;
        r_s7_yr  <= w_yr_prod[50:utc_pkg::DIV7305_SHIFT];

        r_s8_tod <= r_s7_tod;
        r_s8_yr  <= r_s7_yr;
        r_s8_doy <= n_doy;

        r_s9_tod <= r_s8_tod;
        r_s9_yr  <= r_s8_yr;
        r_s9_doy <= r_s8_doy;
        r_s9_mon <= n_mon;

        r_o_sec  <= r_s9_tod.sec;
        r_o_min  <= r_s9_tod.minute;
        r_o_hour <= r_s9_tod.hour;
        r_o_year <= n_year;
        r_o_mon  <= n_mon_out;
        r_o_day  <= n_day;
    end

    assign o_strobe           = r_vld[5];
    assign o_second_of_minute = r_o_sec;
    assign o_minute_of_hour   = r_o_min;
    assign o_hour_of_day      = r_o_hour;
    assign o_year_offset      = r_o_year;
    assign o_month_of_year    = r_o_mon;
    assign o_day_of_month     = r_o_day;

endmodule

[rtl/utc_tod.sv]
// Time-of-day split: seconds, minutes, hours and day count, four stages.
`timescale 1ns / 1ps

module utc_tod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_secs,
    output logic               o_valid,
    output utc_pkg::t_tod      o_tod
);

    logic [60:0] w_prod1;
    logic [55:0] w_prod2;
    logic [35:0] w_prod3;

    logic [31:0] r_s1_t;
    logic [26:0] r_s1_q1;
    logic [5:0]  r_s2_sec;
    logic [26:0] r_s2_q1;
    logic [20:0] r_s2_q2;
    logic [5:0]  r_s3_sec;
    logic [5:0]  r_s3_min;
    logic [20:0] r_s3_q2;
    logic [15:0] r_s3_q3;
    utc_pkg::t_tod r_s4_tod;
    logic [3:0]  r_vld;

    logic [5:0]  n_sec;
    logic [5:0]  n_min;
    logic [4:0]  n_hour;

    // seconds / 60 = (seconds >> 2) / 15
    assign w_prod1 = 61'(i_secs[31:2]) * 61'(utc_pkg::DIV15_MUL);
    assign w_prod2 = 56'(r_s1_q1[26:2]) * 56'(utc_pkg::DIV15_MUL);
    // hours / 24 = (hours >> 3) / 3
    assign w_prod3 = 36'(r_s2_q2[20:3]) * 36'(utc_pkg::DIV3_MUL);

    // remainders: x - 60q = x - 64q + 4q, x - 24q = x - 16q - 8q; low bits only
    assign n_sec  = 6'({1'b0, r_s1_t} - ({r_s1_q1, 6'b0} - {4'b0, r_s1_q1, 2'b0}));
    assign n_min  = 6'({6'b0, r_s2_q1}
                       - ({6'b0, r_s2_q2, 6'b0} - {10'b0, r_s2_q2, 2'b0}));
    assign n_hour = 5'({r_s3_q2} - 21'({r_s3_q3, 4'b0} + {1'b0, r_s3_q3, 3'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_t   <= i_secs;
        r_s1_q1  <= w_prod1[60:utc_pkg::DIV15_SHIFT];

        r_s2_sec <= n_sec;
        r_s2_q1  <= r_s1_q1;
        r_s2_q2  <= w_prod2[54:utc_pkg::DIV15_SHIFT];

        r_s3_sec <= r_s2_sec;
        r_s3_min <= n_min;
        r_s3_q2  <= r_s2_q2;
        r_s3_q3  <= w_prod3[34:utc_pkg::DIV3_SHIFT];

        r_s4_tod.sec    <= r_s3_sec;
        r_s4_tod.minute <= r_s3_min;
        r_s4_tod.hour   <= n_hour;
        r_s4_tod.day    <= r_s3_q3;
    end

    assign o_valid = r_vld[3];
    assign o_tod   = r_s4_tod;

endmodule
